@@ design/cse_pkg.sv @@
package cse_pkg;

   // Fixed field widths
   localparam int ELEM_W   = 16;
   localparam int SIM_W    = 16;
   localparam int STATUS_W = 2;

   // Accumulators wrap modulo 2^48
   localparam int ACC_W  = 48;
   localparam int WIDE_W = 2 * ACC_W;

   // Shared multiplier: signed operands, wide enough for 24-bit unsigned limbs
   localparam int LIMB_W = ACC_W / 2;
   localparam int MUL_W  = LIMB_W + 1;
   localparam int PROD_W = 2 * MUL_W;

   // Ratio search: quotient of 2^28 * dot^2 / (na * nb) and its integer root
   localparam int QUO_W  = 28;
   localparam int ROOT_W = QUO_W / 2;

   // Q1.14 one
   localparam logic [SIM_W-1:0] Q14_ONE = SIM_W'(16384);

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERONORM = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOOLONG  = 2'd2;

   // Parameter defaults
   localparam int MAX_LENGTH_DEF   = 4096;
   localparam int ELEMENT_BITS_DEF = 16;

endpackage

@@ design/cse_mult.sv @@
module cse_mult (
   input  logic                                clock,
   input  logic signed [cse_pkg::MUL_W-1:0]    op_a,
   input  logic signed [cse_pkg::MUL_W-1:0]    op_b,
   output logic signed [cse_pkg::PROD_W-1:0]   prod
);
   import cse_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   // Register the product; the caller reads it in the cycle after issue
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

@@ design/cosine_similarity_engine_unit.sv @@
// Cosine similarity of two equal-length vectors, streamed as element pairs.
//
// Request channel (req_*): one element pair per request, A in tdata[15:0],
// B in tdata[31:16], both signed Q4.12; req_tlast marks the final pair.
// Response channel (rsp_*): one response per vector, similarity in Q1.14 on
// rsp_tdata and the status code on rsp_tuser (ok, zero norm, too long).
//
// One shared 25x25 multiplier does all products. Each pair is handled in
// order: accept, then the products a*b, a*a, b*b and the last accumulate.
// After the last pair, the ratio takes a check, the two 48x48 products in
// 24-bit limbs, the restoring divide and the bit-by-bit square root (one
// multiply and compare per root bit).
// Vectors that are too long or have a zero norm finish after the check.
// req_tready is high only while the sequencer is idle.
//
// The response sits in an output register, so the next vector may start
// while it waits; only a second finished result waits for rsp_tready.
// Reset is synchronous, active high: it clears the sums, the pair count,
// the sequencer and the response valid flag.
module cosine_similarity_engine_unit #(
   parameter int MAX_LENGTH   = cse_pkg::MAX_LENGTH_DEF,
   parameter int ELEMENT_BITS = cse_pkg::ELEMENT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [2*cse_pkg::ELEM_W-1:0]      req_tdata,   // a_element, b_element
   input  logic                              req_tlast,   // last_element
   // Response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cse_pkg::SIM_W-1:0]         rsp_tdata,   // similarity
   output logic [cse_pkg::STATUS_W-1:0]      rsp_tuser    // status
);
   import cse_pkg::*;

   // Used element bits: never more than the field carries
   localparam int EB    = (ELEMENT_BITS < ELEM_W) ? ELEMENT_BITS : ELEM_W;
   // One spare bit so a field narrower than the element width reads as unsigned
   localparam int OP_W  = ELEM_W + 1;
   localparam int CNT_W = $clog2(MAX_LENGTH + 2);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LENGTH);

   // Sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_AB    = 4'd1;
   localparam logic [3:0] S_AA    = 4'd2;
   localparam logic [3:0] S_BB    = 4'd3;
   localparam logic [3:0] S_ACC   = 4'd4;
   localparam logic [3:0] S_CHECK = 4'd5;
   localparam logic [3:0] S_MUL   = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_SQ_IS = 4'd8;
   localparam logic [3:0] S_SQ_CM = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   localparam logic [4:0] DIV_LAST = 5'(QUO_W - 1);
   localparam logic [3:0] ROOT_TOP = 4'(ROOT_W - 1);

   // Control state
   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ACC_W-1:0] dot_ff, dot_in;
   logic [ACC_W-1:0] na_ff, na_in;
   logic [ACC_W-1:0] nb_ff, nb_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic signed [OP_W-1:0]   a_ff, a_in;
   logic signed [OP_W-1:0]   b_ff, b_in;
   logic                     last_ff, last_in;
   logic [ACC_W-1:0]         mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [WIDE_W-1:0]        num_ff, num_in;
   logic [WIDE_W-1:0]        den_ff, den_in;
   logic [WIDE_W-1:0]        acc_ff, acc_in;
   logic                     sel_ff, sel_in;
   logic [2:0]               step_ff, step_in;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic [4:0]               div_cnt_ff, div_cnt_in;
   logic [ROOT_W-1:0]        root_ff, root_in;
   logic [3:0]               bit_ff, bit_in;
   logic [SIM_W-1:0]         res_sim_ff, res_sim_in;
   logic [STATUS_W-1:0]      res_st_ff, res_st_in;
   logic [SIM_W-1:0]         rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]      rsp_user_ff, rsp_user_in;

   // Shared multiplier
   logic signed [MUL_W-1:0]  op_a, op_b;
   logic signed [PROD_W-1:0] prod;
   logic [ACC_W-1:0]         prod48;

   // Helpers
   logic signed [EB-1:0] a_low, b_low;
   logic [ACC_W-1:0]     src_x, src_y;
   logic [LIMB_W-1:0]    limb_x, limb_y;
   logic [WIDE_W-1:0]    prod_sh;
   logic [WIDE_W-1:0]    acc_sum;
   logic [WIDE_W-1:0]    rem2;
   logic                 div_bit;
   logic [ROOT_W-1:0]    trial;
   logic                 sq_fit;
   logic [ROOT_W-1:0]    root_next;
   logic [SIM_W-1:0]     qv;
   logic                 accept;
   logic                 out_free;

   cse_mult u_mult (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign a_low    = req_tdata[EB-1:0];
   assign b_low    = req_tdata[ELEM_W+EB-1:ELEM_W];
   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign prod48   = prod[ACC_W-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Limb selection for the wide products: x0*y0, x0*y1, x1*y0, x1*y1
   assign src_x  = sel_ff ? na_ff : mag_ff;
   assign src_y  = sel_ff ? nb_ff : mag_ff;
   assign limb_x = step_ff[1] ? src_x[ACC_W-1:LIMB_W] : src_x[LIMB_W-1:0];
   assign limb_y = step_ff[0] ? src_y[ACC_W-1:LIMB_W] : src_y[LIMB_W-1:0];

   assign trial = root_ff | (ROOT_W'(1) << bit_ff);

   // Operand mux for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         S_AB: begin
            op_a = MUL_W'(a_ff);
            op_b = MUL_W'(b_ff);
         end
         S_AA: begin
            op_a = MUL_W'(a_ff);
            op_b = MUL_W'(a_ff);
         end
         S_BB: begin
            op_a = MUL_W'(b_ff);
            op_b = MUL_W'(b_ff);
         end
         S_MUL: begin
            op_a = $signed({1'b0, limb_x});
            op_b = $signed({1'b0, limb_y});
         end
         S_SQ_IS: begin
            op_a = $signed(MUL_W'(trial));
            op_b = $signed(MUL_W'(trial));
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Partial product weight follows the limb pair issued in the previous cycle
   always_comb begin
      case (step_ff)
         3'd1:    prod_sh = WIDE_W'(prod48);
         3'd2:    prod_sh = WIDE_W'(prod48) << LIMB_W;
         3'd3:    prod_sh = WIDE_W'(prod48) << LIMB_W;
         3'd4:    prod_sh = WIDE_W'(prod48) << (2 * LIMB_W);
         default: prod_sh = '0;
      endcase
   end

   assign acc_sum   = acc_ff + prod_sh;
   assign rem2      = num_ff << 1;
   assign div_bit   = (rem2 >= den_ff);
   assign sq_fit    = (prod[QUO_W-1:0] <= quo_ff);
   assign root_next = sq_fit ? trial : root_ff;
   assign qv        = SIM_W'(root_next);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      dot_in      = dot_ff;
      na_in       = na_ff;
      nb_in       = nb_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      last_in     = last_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      acc_in      = acc_ff;
      sel_in      = sel_ff;
      step_in     = step_ff;
      quo_in      = quo_ff;
      div_cnt_in  = div_cnt_ff;
      root_in     = root_ff;
      bit_in      = bit_ff;
      res_sim_in  = res_sim_ff;
      res_st_in   = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // Sign-extend from the element width; wider elements read unsigned
               a_in    = (ELEMENT_BITS > ELEM_W) ? OP_W'($unsigned(a_low)) : OP_W'(a_low);
               b_in    = (ELEMENT_BITS > ELEM_W) ? OP_W'($unsigned(b_low)) : OP_W'(b_low);
               last_in = req_tlast;
               if (cnt_ff <= MAX_CNT) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               state_in = S_AB;
            end
         end
         S_AB: state_in = S_AA;
         S_AA: begin
            dot_in   = dot_ff + prod48;
            state_in = S_BB;
         end
         S_BB: begin
            na_in    = na_ff + prod48;
            state_in = S_ACC;
         end
         S_ACC: begin
            nb_in    = nb_ff + prod48;
            state_in = last_ff ? S_CHECK : S_IDLE;
         end
         S_CHECK: begin
            if (cnt_ff > MAX_CNT) begin
               res_sim_in = '0;
               res_st_in  = STATUS_TOOLONG;
               state_in   = S_DONE;
            end else if (na_ff == '0 || na_ff[ACC_W-1] || nb_ff == '0 || nb_ff[ACC_W-1]) begin
               res_sim_in = '0;
               res_st_in  = STATUS_ZERONORM;
               state_in   = S_DONE;
            end else begin
               neg_in   = dot_ff[ACC_W-1];
               mag_in   = dot_ff[ACC_W-1] ? (ACC_W'(0) - dot_ff) : dot_ff;
               sel_in   = 1'b0;
               step_in  = '0;
               acc_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // Issue four limb products, accumulate each in the cycle after its issue
            if (step_ff == 3'd4) begin
               acc_in  = '0;
               step_in = '0;
               if (!sel_ff) begin
                  num_in = acc_sum;
                  sel_in = 1'b1;
               end else begin
                  den_in = acc_sum;
                  if (num_ff >= acc_sum) begin
                     // Ratio at or above one: clamp
                     res_sim_in = neg_ff ? (SIM_W'(0) - Q14_ONE) : Q14_ONE;
                     res_st_in  = STATUS_OK;
                     state_in   = S_DONE;
                  end else begin
                     quo_in     = '0;
                     div_cnt_in = '0;
                     state_in   = S_DIV;
                  end
               end
            end else begin
               acc_in  = acc_sum;
               step_in = step_ff + 1'b1;
            end
         end
         S_DIV: begin
            // Restoring divide, one quotient bit per cycle
            num_in     = div_bit ? (rem2 - den_ff) : rem2;
            quo_in     = {quo_ff[QUO_W-2:0], div_bit};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               root_in  = '0;
               bit_in   = ROOT_TOP;
               state_in = S_SQ_IS;
            end
         end
         S_SQ_IS: state_in = S_SQ_CM;
         S_SQ_CM: begin
            // Keep the trial bit when its square still fits the quotient
            root_in = root_next;
            if (bit_ff == '0) begin
               res_sim_in = neg_ff ? (SIM_W'(0) - qv) : qv;
               res_st_in  = STATUS_OK;
               state_in   = S_DONE;
            end else begin
               bit_in   = bit_ff - 1'b1;
               state_in = S_SQ_IS;
            end
         end
         S_DONE: begin
            // Hold until the output register frees, then clear the sums
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_sim_ff;
               rsp_user_in  = res_st_ff;
               dot_in       = '0;
               na_in        = '0;
               nb_in        = '0;
               cnt_in       = '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         dot_ff       <= '0;
         na_ff        <= '0;
         nb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dot_ff       <= dot_in;
         na_ff        <= na_in;
         nb_ff        <= nb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      last_ff     <= last_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      acc_ff      <= acc_in;
      sel_ff      <= sel_in;
      step_ff     <= step_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      res_sim_ff  <= res_sim_in;
      res_st_ff   <= res_st_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import cse_pkg::*;

   localparam int MAX_LEN    = MAX_LENGTH_DEF;
   localparam int PAIR_GOAL  = 1300;  // random element pairs after the directed part
   localparam int SETTLE_CYC = 100;   // covers the ratio pass after a last pair
   // Longest correct quiet stretch: ratio pass + sender gap + response
   // stall + a queued second result. Allow many times that.
   localparam int IDLE_LIMIT = 2000;

   // Ways to fill the element pairs of one vector
   typedef enum int {
      FILL_RANDOM,
      FILL_SMALL,
      FILL_MATCHED,
      FILL_OPPOSED,
      FILL_ZERO_A,
      FILL_ZERO_B
   } fill_e;

   typedef struct packed {
      logic [SIM_W-1:0]    sim;
      logic [STATUS_W-1:0] status;
   } score_t;

   // Tracks the running sums per vector and holds the similarity scores
   // still owed by the block, oldest first.
   class cosine_checker;
      logic [ACC_W-1:0] dot_acc    = '0;
      logic [ACC_W-1:0] norm_a_acc = '0;
      logic [ACC_W-1:0] norm_b_acc = '0;
      int unsigned      pairs      = 0;
      score_t           pending_scores[$];
      int               errors     = 0;
      int               n_ok       = 0;
      int               n_zero     = 0;
      int               n_long     = 0;

      task report(string what);
         errors++;
         if (errors <= 30)
            $display("[%0t] MISMATCH %s", $time, what);
      endtask

      // Largest q with q^2 * na * nb <= 2^28 * mag^2, capped at one in Q1.14
      function logic [14:0] cosine_q14(logic [ACC_W-1:0] mag, logic [ACC_W-1:0] na,
                                       logic [ACC_W-1:0] nb);
         logic [127:0] den, rhs, t2;
         logic [14:0]  q, t;
         den = 128'(na) * 128'(nb);
         rhs = (128'(mag) * 128'(mag)) << 28;
         q = '0;
         for (int i = 14; i >= 0; i--) begin
            t  = q | (15'd1 << i);
            t2 = 128'(t) * 128'(t);
            if (den * t2 <= rhs)
               q = t;
         end
         if (q > 15'd16384)
            q = 15'd16384;
         return q;
      endfunction

      function void note_pair(logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b, logic last);
         logic signed [31:0] ab, aa, bb;
         logic [ACC_W-1:0]   mag;
         logic [SIM_W-1:0]   q16;
         score_t             s;
         ab = $signed(a) * $signed(b);
         aa = $signed(a) * $signed(a);
         bb = $signed(b) * $signed(b);
         dot_acc    = dot_acc    + {{(ACC_W-32){ab[31]}}, ab};
         norm_a_acc = norm_a_acc + {{(ACC_W-32){aa[31]}}, aa};
         norm_b_acc = norm_b_acc + {{(ACC_W-32){bb[31]}}, bb};
         if (pairs <= MAX_LEN)
            pairs++;
         if (!last)
            return;
         s.sim = '0;
         if (pairs > MAX_LEN) begin
            s.status = STATUS_TOOLONG;
         end else if (norm_a_acc == 0 || norm_a_acc[ACC_W-1] ||
                      norm_b_acc == 0 || norm_b_acc[ACC_W-1]) begin
            s.status = STATUS_ZERONORM;
         end else begin
            s.status = STATUS_OK;
            mag = dot_acc[ACC_W-1] ? (ACC_W'(0) - dot_acc) : dot_acc;
            q16 = {1'b0, cosine_q14(mag, norm_a_acc, norm_b_acc)};
            s.sim = dot_acc[ACC_W-1] ? (SIM_W'(0) - q16) : q16;
         end
         pending_scores.push_back(s);
         dot_acc    = '0;
         norm_a_acc = '0;
         norm_b_acc = '0;
         pairs      = 0;
      endfunction

      task check_score(logic [SIM_W-1:0] sim, logic [STATUS_W-1:0] status);
         score_t want;
         if (pending_scores.size() == 0) begin
            report($sformatf("unexpected response sim=%0d status=%0d", $signed(sim), status));
            return;
         end
         want = pending_scores.pop_front();
         if (status != want.status)
            report($sformatf("status got %0d want %0d", status, want.status));
         if (sim != want.sim)
            report($sformatf("similarity got %0d want %0d (status %0d)",
                             $signed(sim), $signed(want.sim), want.status));
         if (want.status == STATUS_OK)
            n_ok++;
         else if (want.status == STATUS_ZERONORM)
            n_zero++;
         else
            n_long++;
      endtask

      task finish_check();
         if (pending_scores.size() != 0)
            report($sformatf("%0d responses never arrived", pending_scores.size()));
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [2*ELEM_W-1:0]       req_tdata;   // a_element, b_element
   logic                      req_tlast;   // last_element
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [SIM_W-1:0]          rsp_tdata;   // similarity
   logic [STATUS_W-1:0]       rsp_tuser;   // status

   cosine_checker sb;
   bit            send_gaps = 1'b1;
   bit            take_gaps = 1'b1;
   int            n_pairs   = 0;
   int            n_vectors = 0;
   int            idle_cycles = 0;

   cosine_similarity_engine_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // Present one element pair as a request and hold it until the block takes it.
   // Valid stays high across back-to-back requests; it only drops for a gap.
   task automatic send_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
                            input logic last);
      int gap;
      gap = send_gaps ? $urandom_range(0, 16) : 0;
      @(negedge clock);
      if (gap > 0) begin
         // drop valid and scribble on the data lines while idle
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tlast  <= 1'($urandom_range(0, 1));
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_pair(a, b, last);
      n_pairs++;
   endtask

   // Stream one whole vector; the final request carries tlast.
   task automatic send_vector(input int len, input fill_e fill);
      logic [ELEM_W-1:0] a, b;
      for (int k = 0; k < len; k++) begin
         a = ELEM_W'($urandom);
         b = ELEM_W'($urandom);
         case (fill)
            FILL_SMALL: begin
               a = ELEM_W'($urandom_range(0, 255)) - 16'd128;
               b = ELEM_W'($urandom_range(0, 255)) - 16'd128;
            end
            FILL_MATCHED: b = a + ELEM_W'($urandom_range(0, 6)) - 16'd3;
            FILL_OPPOSED: b = 16'd0 - a;
            FILL_ZERO_A:  a = '0;
            FILL_ZERO_B:  b = '0;
            default: ;
         endcase
         send_pair(a, b, k == len - 1);
      end
      n_vectors++;
   endtask

   // Hold off new requests until every owed response has come back.
   task automatic drain_scores();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_scores.size() != 0) @(posedge clock);
   endtask

   // Response side: per response, optionally stall a drawn number of cycles
   // once it shows up; otherwise keep ready high so it is taken at once.
   initial begin : take_responses
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = take_gaps ? $urandom_range(0, 16) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            do @(posedge clock); while (!rsp_tvalid);
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_score(rsp_tdata, rsp_tuser);
         @(negedge clock);
      end
   end

   // Watchdog: end the run if no handshake happens on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[%0t] watchdog: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : run_test
      int    goal, len, pick;
      fill_e fill;
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: single-pair vectors at the field extremes
      send_pair(16'h7FFF, 16'h7FFF, 1'b1);   // identical, exactly one
      send_pair(16'h8000, 16'h8000, 1'b1);   // most negative squared
      send_pair(16'h8000, 16'h7FFF, 1'b1);   // opposite signs, minus one
      send_pair(16'h0000, 16'h1234, 1'b1);   // zero norm on A
      send_pair(16'h4321, 16'h0000, 1'b1);   // zero norm on B
      send_pair(16'h0000, 16'h0000, 1'b1);   // both norms zero
      // orthogonal vectors: ok status with a zero score
      send_pair(16'h0001, 16'h0000, 1'b0);
      send_pair(16'h0000, 16'h0001, 1'b1);
      // anti-parallel small vectors
      send_pair(16'h0001, 16'hFFFF, 1'b0);
      send_pair(16'h0001, 16'hFFFF, 1'b1);
      // alternating bit patterns mixed with extremes
      send_pair(16'h5555, 16'hAAAA, 1'b0);
      send_pair(16'hAAAA, 16'h5555, 1'b0);
      send_pair(16'h7FFF, 16'h8000, 1'b1);
      // 24/25 ratio, truncated
      send_pair(16'h0003, 16'h0004, 1'b0);
      send_pair(16'h0004, 16'h0003, 1'b1);
      drain_scores();

      // Random vectors, mostly short, with gap settings changed now and then
      goal = n_pairs + PAIR_GOAL;
      while (n_pairs < goal) begin
         if (n_vectors % 8 == 0) begin
            send_gaps = ($urandom_range(0, 3) != 0);
            take_gaps = ($urandom_range(0, 3) != 0);
         end
         len  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
         pick = $urandom_range(0, 9);
         fill = (pick > FILL_ZERO_B) ? FILL_RANDOM : fill_e'(pick);
         send_vector(len, fill);
         if ($urandom_range(0, 40) == 0)
            drain_scores();
      end

      // Wind down: release the request side, collect what is owed, then settle
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      sb.finish_check();

      $display("covered %0d element pairs in %0d vectors, directed extremes plus lengths 1 to 64",
               n_pairs, n_vectors);
      $display("responses checked: %0d ok, %0d zero norm, %0d too long; %0d errors",
               sb.n_ok, sb.n_zero, sb.n_long, sb.errors);
      if (sb.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
